// ===== hw/rtl/twm_pkg.sv =====
// twm_pkg: shared types and constants of the trimmed window mean filter
// used by the controller, the datapath and the top level; no dependencies
`default_nettype none

package twm_pkg;

  // field widths fixed by the interface
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned CHAN_W   = 1;

  // the quotient never exceeds the sample range
  localparam int unsigned QUOT_W = SAMPLE_W;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SCAN,
    ST_FLUSH,
    ST_TRIM,
    ST_DIV,
    ST_OUT
  } twm_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic write;
    logic scan;
    logic trim;
    logic div;
    logic load_out;
  } twm_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic chan_bad;
    logic scan_last;
    logic out_free;
  } twm_sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/twm_ram.sv =====
// twm_ram: generic single write port, single read port RAM with registered read
// no dependencies
`default_nettype none

module twm_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem_r[raddr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/twm_ctrl.sv =====
// twm_ctrl: sequencing state machine of the trimmed window mean filter
// depends on twm_pkg for the state, command and status types
`default_nettype none

module twm_ctrl
  import twm_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire twm_sts_t sts,
  output twm_cmd_t      cmd
);

  twm_state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = !rst_n;
        if (in_valid && rst_n) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_WRITE;
        end
      end
      ST_WRITE: begin
        if (sts.chan_bad) begin
          state_nxt = ST_OUT;
        end else begin
          cmd.write = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_last) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        state_nxt = ST_TRIM;
      end
      ST_TRIM: begin
        cmd.trim  = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/twm_dp.sv =====
// twm_dp: window store, scan accumulators, reciprocal divider and output register
// depends on twm_pkg and twm_ram
`default_nettype none

module twm_dp
  import twm_pkg::*;
#(
  parameter int unsigned WINDOW   = 16,
  parameter int unsigned CHANNELS = 2
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire twm_cmd_t            cmd,
  output twm_sts_t                 sts,
  input  wire logic [CHAN_W-1:0]   in_channel,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  input  wire logic                out_stall,
  output logic                     out_valid,
  output logic      [QUOT_W-1:0]   out_trimmed_mean
);

  localparam int unsigned IDX_W      = $clog2(WINDOW);
  localparam int unsigned CHW        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned ADDR_W     = CHW + IDX_W;
  localparam int unsigned DEPTH      = 2 ** ADDR_W;
  localparam int unsigned KEPT       = WINDOW - 2;
  localparam int unsigned ROUND_HALF = KEPT / 2;
  localparam int unsigned SUM_W      = SAMPLE_W + IDX_W + 1;
  localparam bit          ONE_CHAN   = (CHANNELS == 1);
  localparam int unsigned KEPT_LG    = $clog2(KEPT);
  localparam int unsigned RECIP_SH   = SUM_W + KEPT_LG;
  localparam int unsigned RECIP_W    = SUM_W + 1;
  localparam int unsigned PROD_W     = SUM_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** RECIP_SH + KEPT - 1) / KEPT);

  logic [CHW-1:0]      ch_r;
  logic [SAMPLE_W-1:0] sample_r;
  logic                chan_bad_r;
  logic [IDX_W-1:0]    wp_r [CHANNELS];
  logic                full_r [CHANNELS];
  logic [IDX_W-1:0]    cur_wp;
  logic [IDX_W-1:0]    wp_nxt;
  logic [IDX_W-1:0]    scan_idx_r;
  logic                acc_en_r;
  logic                ent_ok_r;
  logic [SAMPLE_W-1:0] rdata;
  logic [SAMPLE_W-1:0] ent_val;
  logic [SUM_W-1:0]    sum_r;
  logic [SAMPLE_W-1:0] hi_r;
  logic [SAMPLE_W-1:0] lo_r;
  logic [SUM_W-1:0]    dvd_r;
  logic [PROD_W-1:0]   prod;
  logic [QUOT_W-1:0]   quot_r;
  logic                out_valid_r;
  logic [QUOT_W-1:0]   out_data_r;

  // capture of the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ch_r       <= CHW'(in_channel);
      sample_r   <= in_sample;
      chan_bad_r <= in_channel[0] && ONE_CHAN;
    end
  end

  // write pointer of the current channel and its advance with wrap
  assign cur_wp = wp_r[ch_r];
  assign wp_nxt = (cur_wp == IDX_W'(WINDOW - 1)) ? '0 : cur_wp + 1'b1;

  // per channel pointers and window-full flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wp_r[c]   <= '0;
        full_r[c] <= 1'b0;
      end
    end else if (cmd.write) begin
      wp_r[ch_r] <= wp_nxt;
      if (wp_nxt == '0) begin
        full_r[ch_r] <= 1'b1;
      end
    end
  end

  // window store, one row of WINDOW entries per channel
  twm_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.write),
    .waddr ({ch_r, cur_wp}),
    .wdata (sample_r),
    .raddr ({ch_r, scan_idx_r}),
    .rdata (rdata)
  );

  // scan address and read-data qualifiers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r <= '0;
      acc_en_r   <= 1'b0;
    end else begin
      acc_en_r <= cmd.scan;
      if (cmd.capture) begin
        scan_idx_r <= '0;
      end else if (cmd.scan) begin
        scan_idx_r <= scan_idx_r + 1'b1;
      end
    end
  end

  // entries not yet written since reset read as zero
  always_ff @(posedge clk) begin
    ent_ok_r <= full_r[ch_r] || (scan_idx_r < cur_wp);
  end

  assign ent_val = ent_ok_r ? rdata : '0;

  // sum, max and min over the window
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sum_r <= '0;
      hi_r  <= '0;
      lo_r  <= SAMPLE_MAX;
    end else if (acc_en_r) begin
      sum_r <= sum_r + SUM_W'(ent_val);
      if (ent_val > hi_r) begin
        hi_r <= ent_val;
      end
      if (ent_val < lo_r) begin
        lo_r <= ent_val;
      end
    end
  end

  // dividend: trimmed sum plus half the kept count for rounding
  always_ff @(posedge clk) begin
    if (cmd.trim) begin
      dvd_r <= sum_r - SUM_W'(hi_r) - SUM_W'(lo_r) + SUM_W'(ROUND_HALF);
    end
  end

  // divide by the kept count as a multiply by its rounded-up reciprocal,
  // exact for every dividend below 2**SUM_W
  assign prod = PROD_W'(dvd_r) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      quot_r <= '0;
    end else if (cmd.div) begin
      quot_r <= prod[RECIP_SH +: QUOT_W];
    end
  end

  // output register, free when empty or being taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data_r <= quot_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_trimmed_mean = out_data_r;

  // status back to the controller
  assign sts.chan_bad  = chan_bad_r;
  assign sts.scan_last = (scan_idx_r == IDX_W'(WINDOW - 1));
  assign sts.out_free  = !out_valid_r || !out_stall;

endmodule

`default_nettype wire

// ===== hw/rtl/trimmed_window_mean_filter.sv =====
// trimmed_window_mean_filter: top level, joins controller and datapath
// depends on twm_pkg, twm_ctrl, twm_dp and twm_ram
//
// Usage:
//   Input channel (in_valid / in_stall, in_channel, in_sample): each transaction
//   writes the sample into the selected channel's circular window and advances
//   that channel's write pointer. Output channel (out_valid / out_stall,
//   out_trimmed_mean): exactly one result per input transaction, the rounded
//   mean of the window without one largest and one smallest entry; with
//   CHANNELS = 1 a transaction on channel 1 writes nothing and yields zero.
//   Steps: after acceptance the block writes the sample, reads the whole
//   window through the single read port of the window store, drains the
//   read data, trims, divides by a reciprocal multiply and loads the output
//   register. No new transaction is taken until the block is back in idle.
//   in_stall stays high while a transaction is in work and during reset.
//   Reset clears all write pointers and window-full flags; entries never
//   written read as zero, so no clearing pass is needed.
//   A stalled result holds in the output register while the next input is
//   accepted; the next result waits in the datapath until the output is free.
`default_nettype none

module trimmed_window_mean_filter
  import twm_pkg::*;
#(
  parameter int unsigned WINDOW   = 16,
  parameter int unsigned CHANNELS = 2
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [CHAN_W-1:0]   in_channel,
  input  wire logic [SAMPLE_W-1:0] in_sample,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [QUOT_W-1:0]   out_trimmed_mean
);

  twm_cmd_t cmd;
  twm_sts_t sts;

  // sequencing
  twm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage and arithmetic
  twm_dp #(
    .WINDOW   (WINDOW),
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_channel       (in_channel),
    .in_sample        (in_sample),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_trimmed_mean (out_trimmed_mean)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/twm_checker.sv =====
// twm_checker: port-level assertions for the trimmed window mean filter
// depends on twm_pkg; bound to trimmed_window_mean_filter below
`default_nettype none

module twm_checker
  import twm_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_valid,
  input wire logic                in_stall,
  input wire logic [CHAN_W-1:0]   in_channel,
  input wire logic [SAMPLE_W-1:0] in_sample,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire logic [QUOT_W-1:0]   out_trimmed_mean
);

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // an accepted transaction keeps the input side busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input not stalled after accepted transaction");

  // no result appears right after acceptance
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !$rose(out_valid))
    else $error("result appeared one cycle after acceptance");

  // a new result is only produced while a transaction is in work
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without a transaction in work");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_trimmed_mean))
    else $error("stalled result changed");

  // a stalled input transaction holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_channel) && $stable(in_sample))
    else $error("stalled input transaction changed");

endmodule

bind trimmed_window_mean_filter twm_checker u_twm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_channel       (in_channel),
  .in_sample        (in_sample),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_trimmed_mean (out_trimmed_mean)
);

`default_nettype wire
